>>> rtl/quadratic_probe_hash_table_assert.svh
// assertion macros shared by the hash table rtl
// expects clk and rst_n in the scope of each use
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

// consequent checked in the same cycle
`define QPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define QPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/qpht_pkg.sv
// shared constants, codes and controller/datapath interface structs
// no dependencies
`default_nettype none

package qpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int KEY_W       = 31;
    localparam int CNT_W       = 32;
    localparam int DIV_CNT_W   = $clog2(KEY_W);
    localparam int SEARCH_PROBE_LIMIT = 10009;
    localparam int LIMIT_W     = 14;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic       clr_wr;
        logic       load;
        logic       div_step;
        logic       probe_init;
        logic       probe_adv;
        logic       mem_wr;
        logic       cnt_ins;
        logic       cnt_srch;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_hit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic op;
        logic slot_used;
        logic key_match;
        logic first_probe;
        logic last_probe;
        logic at_limit;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/qpht_ctrl.sv
// controller fsm: clearing pass, key reduction, probe walk, result hand-off
// depends on qpht_pkg and the assertion header
`default_nettype none
`include "quadratic_probe_hash_table_assert.svh"

module qpht_ctrl
    import qpht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PINIT,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       hit_reg, hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            status_reg <= ST_INSERTED;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        cmd            = '0;
        cmd.res_status = status_reg;
        cmd.res_hit    = hit_reg;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_PINIT;
            end
            S_PINIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // insert counts an occupied home and every later probe,
                // search counts every probe after the home slot
                if (sts.op == OP_INSERT)
                    cmd.cnt_ins = !sts.first_probe || sts.slot_used;
                else
                    cmd.cnt_srch = !sts.first_probe;
                if (sts.op == OP_INSERT)
                begin
                    priority if (!sts.slot_used)
                    begin
                        cmd.mem_wr  = 1'b1;
                        status_next = ST_INSERTED;
                        hit_next    = 1'b1;
                        state_next  = S_DONE;
                    end
                    else if (sts.last_probe)
                    begin
                        status_next = ST_FULL;
                        hit_next    = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.probe_adv = 1'b1;
                        state_next    = S_READ;
                    end
                end
                else
                begin
                    priority if (sts.slot_used && sts.key_match)
                    begin
                        status_next = ST_FOUND;
                        hit_next    = 1'b1;
                        state_next  = S_DONE;
                    end
                    else if ((sts.first_probe && !sts.slot_used) || sts.last_probe
                             || sts.at_limit)
                    begin
                        status_next = ST_NOT_FOUND;
                        hit_next    = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.probe_adv = 1'b1;
                        state_next    = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `QPHT_ASSERT_NEXT(a_accept_starts_div, in_valid && in_ready, state_reg == S_DIV,
        "accepted beat did not start the key reduction")
    `QPHT_ASSERT_NOW(a_wr_only_on_free, cmd.mem_wr, state_reg == S_CHECK && !sts.slot_used,
        "insert write to an occupied slot")
    `QPHT_ASSERT_NEXT(a_result_goes_idle, cmd.res_load, state_reg == S_IDLE,
        "result load did not return to idle")

endmodule

`default_nettype wire

>>> rtl/qpht_dp.sv
// datapath: size register, bit-serial key reduction, probe generator,
// slot memory, saturating counters and result register; uses qpht_pkg
`default_nettype none
`include "quadratic_probe_hash_table_assert.svh"

module qpht_dp
    import qpht_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [SIZE_W-1:0] table_size,
    input  wire logic              operation,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [1:0]             status,
    output logic [SLOT_W-1:0]      slot,
    output logic [CNT_W-1:0]       insert_collisions,
    output logic [CNT_W-1:0]       search_collisions,
    input  wire cmd_t              cmd,
    output sts_t                   sts
);

    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    n_reg;
    logic [SIZE_W-1:0]    n_eff;
    logic                 op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     key_sh_reg;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W:0]      rem_trial;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SLOT_W-1:0]    s_reg, s_next;
    logic [SLOT_W-1:0]    d_reg, d_next;
    logic [SIZE_W-1:0]    s_sum, d_sum, d_once;
    logic [SIZE_W-1:0]    i_reg;
    logic [SLOT_W-1:0]    clr_reg;
    logic [CNT_W-1:0]     ins_cnt_reg, srch_cnt_reg;
    logic [CNT_W-1:0]     ins_out_reg, srch_out_reg;
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [SLOT_W-1:0]    slot_reg;

    logic [KEY_W:0]       mem [TABLE_DEPTH];
    logic [KEY_W:0]       rdata_reg;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wa;
    logic [KEY_W:0]       mem_wd;

    // a zero size acts as one, an oversize as the full depth
    always_comb
    begin
        priority if (size_reg == '0)
            n_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(TABLE_DEPTH))
            n_eff = SIZE_W'(TABLE_DEPTH);
        else
            n_eff = size_reg;
    end

    // restoring remainder, one key bit per cycle
    always_comb
    begin
        rem_trial = {rem_reg, key_sh_reg[KEY_W-1]};
        if (rem_trial >= {1'b0, n_reg})
            rem_trial = rem_trial - {1'b0, n_reg};
        rem_next = rem_trial[SIZE_W-1:0];
    end

    // (home + i*i) mod n by adding odd steps, all kept below n
    always_comb
    begin
        s_sum = {1'b0, s_reg} + {1'b0, d_reg};
        if (s_sum >= n_reg)
            s_sum = s_sum - n_reg;
        s_next = s_sum[SLOT_W-1:0];
        d_once = {1'b0, d_reg} + SIZE_W'(2);
        if (d_once >= n_reg)
            d_once = d_once - n_reg;
        d_sum = d_once;
        if (d_sum >= n_reg)
            d_sum = d_sum - n_reg;
        d_next = d_sum[SLOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_W'(TABLE_DEPTH);
            clr_reg       <= '0;
            ins_cnt_reg   <= '0;
            srch_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                size_reg <= table_size;
            if (cmd.clr_wr)
                clr_reg <= clr_reg + SLOT_W'(1);
            if (cmd.cnt_ins && ins_cnt_reg != '1)
                ins_cnt_reg <= ins_cnt_reg + CNT_W'(1);
            if (cmd.cnt_srch && srch_cnt_reg != '1)
                srch_cnt_reg <= srch_cnt_reg + CNT_W'(1);
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            key_reg     <= key;
            key_sh_reg  <= key;
            n_reg       <= n_eff;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            key_sh_reg  <= {key_sh_reg[KEY_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.probe_init)
        begin
            s_reg <= rem_reg[SLOT_W-1:0];
            d_reg <= (n_reg == SIZE_W'(1)) ? '0 : SLOT_W'(1);
            i_reg <= '0;
        end
        if (cmd.probe_adv)
        begin
            s_reg <= s_next;
            d_reg <= d_next;
            i_reg <= i_reg + SIZE_W'(1);
        end
        // counters are captured with the result so a waiting beat stays stable
        if (cmd.res_load)
        begin
            status_reg   <= cmd.res_status;
            slot_reg     <= cmd.res_hit ? s_reg : '0;
            ins_out_reg  <= ins_cnt_reg;
            srch_out_reg <= srch_cnt_reg;
        end
    end

    // slot memory: bit KEY_W is the used mark, cleared by the sweep after reset
    assign mem_we = cmd.clr_wr || cmd.mem_wr;
    assign mem_wa = cmd.clr_wr ? clr_reg : s_reg;
    assign mem_wd = cmd.clr_wr ? '0 : {1'b1, key_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[s_reg];
    end

    always_comb
    begin
        sts.clr_last    = (clr_reg == SLOT_W'(TABLE_DEPTH - 1));
        sts.div_last    = (div_cnt_reg == DIV_CNT_W'(KEY_W - 1));
        sts.op          = op_reg;
        sts.slot_used   = rdata_reg[KEY_W];
        sts.key_match   = (rdata_reg[KEY_W-1:0] == key_reg);
        sts.first_probe = (i_reg == '0);
        sts.last_probe  = ((i_reg + SIZE_W'(1)) >= n_reg);
        sts.at_limit    = ({{(LIMIT_W-SIZE_W){1'b0}}, i_reg} >= LIMIT_W'(SEARCH_PROBE_LIMIT));
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign slot              = slot_reg;
    assign insert_collisions = ins_out_reg;
    assign search_collisions = srch_out_reg;

    `QPHT_ASSERT_NOW(a_probe_in_range, cmd.probe_adv, {1'b0, s_next} < n_reg,
        "probe slot outside the table")
    `QPHT_ASSERT_NEXT(a_ins_cnt_monotone, 1'b1, ins_cnt_reg >= $past(ins_cnt_reg),
        "insert counter went down")
    `QPHT_ASSERT_NOW(a_single_writer, cmd.clr_wr, !cmd.mem_wr,
        "clear sweep and insert write collide")

endmodule

`default_nettype wire

>>> rtl/quadratic_probe_hash_table.sv
// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// cfg       | cfg_valid, cfg_ready, table_size          | in
// in        | in_valid, in_ready, operation, key        | in
// out       | out_valid, out_ready, status, slot,       | out
//           | insert_collisions, search_collisions      |
// after reset a clearing pass over all 1024 table slots runs; in_ready stays low meanwhile
// per item: accept, key reduction over all 31 key bits, probe setup, then a memory read
// and a compare for each probe, and last the hand-off of the result
// the bit-serial remainder and the single memory read port give this serial schedule
// a stalled out channel holds the result; the next beat is taken while it waits
// cfg beats are taken every cycle; uses qpht_pkg, qpht_ctrl and qpht_dp
`default_nettype none

module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] table_size,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              operation,
    input  wire logic [KEY_W-1:0]  key,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [SLOT_W-1:0]      slot,
    output logic [CNT_W-1:0]       insert_collisions,
    output logic [CNT_W-1:0]       search_collisions
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    qpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qpht_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .table_size        (table_size),
        .operation         (operation),
        .key               (key),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .status            (status),
        .slot              (slot),
        .insert_collisions (insert_collisions),
        .search_collisions (search_collisions),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

`default_nettype wire

>>> tb/sv/quadratic_probe_hash_table_tb.sv
// self-checking testbench for the quadratic probing hash table
// keeps its own copy of the slot store and counters; depends on qpht_pkg and the rtl top
`default_nettype none

module quadratic_probe_hash_table_tb
    import qpht_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] k;
    } request_t;

    typedef struct {
        logic [1:0]        st;
        logic [SLOT_W-1:0] sl;
        logic [CNT_W-1:0]  ins_cnt;
        logic [CNT_W-1:0]  srch_cnt;
    } lookup_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] table_size;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [KEY_W-1:0]  key;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  insert_collisions;
    logic [CNT_W-1:0]  search_collisions;

    quadratic_probe_hash_table DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .table_size(table_size),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .key(key),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .slot(slot),
        .insert_collisions(insert_collisions), .search_collisions(search_collisions)
    );

    // shadow of the table
    bit               shadow_used [TABLE_DEPTH];
    logic [KEY_W-1:0] shadow_key  [TABLE_DEPTH];
    logic [CNT_W-1:0] shadow_ins;
    logic [CNT_W-1:0] shadow_srch;
    logic [SIZE_W-1:0] shadow_size;

    request_t         pending_reqs[$];
    lookup_t          expected_lookups[$];
    logic [KEY_W-1:0] stored_keys[$];

    int  mismatches;
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  tx_hold;
    bit  rx_hold;
    bit  in_beat;

    function automatic logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    function automatic lookup_t probe_table(logic op, logic [KEY_W-1:0] k);
        lookup_t r;
        int unsigned n;
        int unsigned home;
        int unsigned s;
        int unsigned lim;
        n = (shadow_size == 0) ? 1 : (shadow_size > TABLE_DEPTH) ? TABLE_DEPTH : shadow_size;
        home = k % n;
        r.sl = '0;
        if (op == OP_INSERT) begin
            r.st = ST_FULL;
            if (!shadow_used[home]) begin
                shadow_used[home] = 1'b1;
                shadow_key[home] = k;
                r.st = ST_INSERTED;
                r.sl = home[SLOT_W-1:0];
            end
            else begin
                shadow_ins = sat_up(shadow_ins);
                for (int unsigned i = 1; i < n; i++) begin
                    s = (home + i * i) % n;
                    shadow_ins = sat_up(shadow_ins);
                    if (!shadow_used[s]) begin
                        shadow_used[s] = 1'b1;
                        shadow_key[s] = k;
                        r.st = ST_INSERTED;
                        r.sl = s[SLOT_W-1:0];
                        break;
                    end
                end
            end
        end
        else begin
            r.st = ST_NOT_FOUND;
            if (shadow_used[home]) begin
                if (shadow_key[home] == k) begin
                    r.st = ST_FOUND;
                    r.sl = home[SLOT_W-1:0];
                end
                else begin
                    lim = n - 1;
                    if (lim > SEARCH_PROBE_LIMIT) lim = SEARCH_PROBE_LIMIT;
                    for (int unsigned i = 1; i <= lim; i++) begin
                        shadow_srch = sat_up(shadow_srch);
                        s = (home + i * i) % n;
                        if (shadow_used[s] && shadow_key[s] == k) begin
                            r.st = ST_FOUND;
                            r.sl = s[SLOT_W-1:0];
                            break;
                        end
                    end
                end
            end
        end
        r.ins_cnt = shadow_ins;
        r.srch_cnt = shadow_srch;
        return r;
    endfunction

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // input driver
    always @(negedge clk) begin
        request_t r;
        if (in_valid && !in_beat) begin
            in_valid <= 1'b1;
        end
        else if (!rst_n || tx_hold || pending_reqs.size() == 0 ||
                 $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
        end
        else begin
            r = pending_reqs.pop_front();
            in_valid  <= 1'b1;
            operation <= r.op;
            key       <= r.k;
        end
    end

    // output ready
    always @(negedge clk) begin
        if (rx_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (rx_hold) begin
            repeat (3000) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge clk) begin
        lookup_t e;
        in_beat = in_valid && in_ready;
        if (in_beat)
            expected_lookups.push_back(probe_table(operation, key));
        if (out_valid && out_ready) begin
            if (expected_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d slot %0d", status, slot);
            end
            else begin
                e = expected_lookups.pop_front();
                if (status !== e.st || slot !== e.sl || insert_collisions !== e.ins_cnt ||
                    search_collisions !== e.srch_cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d sl %0d ic %0d sc %0d, got %0d %0d %0d %0d",
                                 e.st, e.sl, e.ins_cnt, e.srch_cnt,
                                 status, slot, insert_collisions, search_collisions);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_lookups.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_size(logic [SIZE_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid  <= 1'b1;
        table_size <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_size = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(logic op, logic [KEY_W-1:0] k);
        request_t r;
        r.op = op;
        r.k = k;
        pending_reqs.push_back(r);
        if (op == OP_INSERT) stored_keys.push_back(k);
    endtask

    task automatic push_random(int count);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0)
                k = $urandom_range(200);
            else
                k = $urandom;
            if ($urandom_range(1) == 0)
                push_req(OP_INSERT, k);
            else if (stored_keys.size() != 0 && $urandom_range(9) < 7)
                push_req(OP_SEARCH, stored_keys[$urandom_range(stored_keys.size() - 1)]);
            else
                push_req(OP_SEARCH, k);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        table_size = '0;
        in_valid = 1'b0;
        operation = 1'b0;
        key = '0;
        out_ready = 1'b0;
        in_beat = 1'b0;
        mismatches = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        tx_hold = 1'b0;
        rx_hold = 1'b0;
        shadow_ins = '0;
        shadow_srch = '0;
        shadow_size = 1024;
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: tiny tables, collisions, full table, key extremes
        set_size(4);
        push_req(OP_SEARCH, 31'd5);             // empty home
        push_req(OP_INSERT, 31'd0);
        push_req(OP_INSERT, 31'd4);             // collides at home
        push_req(OP_INSERT, 31'd8);             // only two slots reachable
        push_req(OP_SEARCH, 31'd4);
        push_req(OP_SEARCH, 31'd0);
        push_req(OP_SEARCH, 31'd12);            // probed to the limit
        push_req(OP_INSERT, 31'h7FFF_FFFF);
        push_req(OP_SEARCH, 31'h7FFF_FFFF);
        push_req(OP_INSERT, 31'h7FFF_FFFB);
        push_req(OP_INSERT, 31'h7FFF_FFF7);
        set_size(1);
        push_req(OP_SEARCH, 31'd0);             // slot 0 from size 4 still there
        push_req(OP_INSERT, 31'd9);             // full at size one
        push_req(OP_SEARCH, 31'd9);
        push_req(OP_SEARCH, 31'h7FFF_FFFF);
        set_size(1024);
        push_req(OP_INSERT, 31'd1023);
        push_req(OP_INSERT, 31'd2047);
        push_req(OP_SEARCH, 31'd2047);
        push_req(OP_SEARCH, 31'd3071);
        push_req(OP_INSERT, 31'h7FFF_FFFF);

        // oversized setting acts as full depth
        set_size(11'h7FF);
        push_random(150);

        set_size(0);
        tx_idle_pct = 65;
        push_random(100);

        set_size(13);
        tx_idle_pct = 0;
        rx_stall_pct = 65;
        push_random(400);

        set_size(64);
        tx_idle_pct = 37;
        rx_stall_pct = 37;
        push_random(400);

        // receiver blocks while the sender keeps offering
        set_size(1024);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        push_random(300);
        rx_hold = 1'b1;

        set_size(7);
        tx_idle_pct = 20;
        rx_stall_pct = 20;
        push_random(100);
        while (pending_reqs.size() > 50) @(posedge clk);
        tx_hold = 1'b1;
        while (in_valid || expected_lookups.size() != 0) @(posedge clk);
        tx_hold = 1'b0;
        push_random(100);

        set_size(1);
        push_random(150);

        wait_idle();
        repeat (2200) @(posedge clk);
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #500ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/qpht_pkg.sv
rtl/qpht_ctrl.sv
rtl/qpht_dp.sv
rtl/quadratic_probe_hash_table.sv
tb/sv/quadratic_probe_hash_table_tb.sv
